// ----- src/dhcp_message_field_extractor_top_assert.svh -----
// Assertion macros for the DHCP field extractor.
// Used by the parser, the result queue and the top level; needs clk and rst in scope.
`ifndef DHCP_MESSAGE_FIELD_EXTRACTOR_TOP_ASSERT_SVH
`define DHCP_MESSAGE_FIELD_EXTRACTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DMFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define DMFE_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define DMFE_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define DMFE_ASSERT(label, prop, msg)
`define DMFE_ASSERT_IMP(label, pre, post, msg)
`define DMFE_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ----- src/dmfe_pkg.sv -----
// Shared types and constants of the DHCP field extractor.
// No dependencies; imported by every module of the block.
package dmfe_pkg;

  localparam int OPTION_AREA_BYTES = 312;
  localparam int NAME_MAX = 64;

  localparam logic [9:0] OFFSET_MAX = 10'd1023;
  localparam int AREA_SUM = 236 + OPTION_AREA_BYTES;
  localparam logic [9:0] AREA_END = 10'((AREA_SUM > 1023) ? 1023 : AREA_SUM);
  localparam logic [8:0] NAME_LIMIT = 9'(NAME_MAX - 1);

  localparam logic [31:0] COOKIE = 32'h6382_5363;

  // header offsets at which a field completes
  localparam logic [9:0] OFF_OP         = 10'd0;
  localparam logic [9:0] OFF_XID_END    = 10'd7;
  localparam logic [9:0] OFF_YIADDR_END = 10'd19;
  localparam logic [9:0] OFF_SIADDR_END = 10'd23;
  localparam logic [9:0] OFF_GIADDR_END = 10'd27;
  localparam logic [9:0] OFF_MAC_END    = 10'd33;
  localparam logic [9:0] OFF_COOKIE_END = 10'd239;

  localparam logic [7:0] OPT_PAD     = 8'd0;
  localparam logic [7:0] OPT_MASK    = 8'd1;
  localparam logic [7:0] OPT_ROUTER  = 8'd3;
  localparam logic [7:0] OPT_DNS     = 8'd6;
  localparam logic [7:0] OPT_DOMAIN  = 8'd15;
  localparam logic [7:0] OPT_LEASE   = 8'd51;
  localparam logic [7:0] OPT_MSGTYPE = 8'd53;
  localparam logic [7:0] OPT_SERVER  = 8'd54;
  localparam logic [7:0] OPT_RENEW   = 8'd58;
  localparam logic [7:0] OPT_REBIND  = 8'd59;
  localparam logic [7:0] OPT_END     = 8'd255;

  localparam logic [4:0] KIND_DONE    = 5'd0;
  localparam logic [4:0] KIND_OP      = 5'd1;
  localparam logic [4:0] KIND_XID     = 5'd2;
  localparam logic [4:0] KIND_YIADDR  = 5'd3;
  localparam logic [4:0] KIND_SIADDR  = 5'd4;
  localparam logic [4:0] KIND_GIADDR  = 5'd5;
  localparam logic [4:0] KIND_MAC     = 5'd6;
  localparam logic [4:0] KIND_MSGTYPE = 5'd7;
  localparam logic [4:0] KIND_ROUTER  = 5'd8;
  localparam logic [4:0] KIND_MASK    = 5'd9;
  localparam logic [4:0] KIND_SERVER  = 5'd10;
  localparam logic [4:0] KIND_RENEW   = 5'd11;
  localparam logic [4:0] KIND_REBIND  = 5'd12;
  localparam logic [4:0] KIND_LEASE   = 5'd13;
  localparam logic [4:0] KIND_DNS1    = 5'd14;
  localparam logic [4:0] KIND_DNS2    = 5'd15;
  localparam logic [4:0] KIND_NAME    = 5'd16;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_COOKIE = 2'd1;
  localparam logic [1:0] ST_WRONG_OP   = 2'd2;
  localparam logic [1:0] ST_EARLY_END  = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_CODE   = 3'd1,
    PH_LEN    = 3'd2,
    PH_DATA   = 3'd3,
    PH_STOP   = 3'd4,
    PH_SKIP   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [47:0] value;
    logic [7:0]  index;
    logic [1:0]  status;
    logic        last;
  } result_t;

  // up to two results produced by one accepted byte
  typedef struct packed {
    logic    first_valid;
    logic    second_valid;
    result_t first;
    result_t second;
  } push_t;

  // power of two, so the pointers wrap on their own
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

endpackage

// ----- src/dmfe_parser.sv -----
// Per-byte parser: header capture, cookie check and option walk.
// Depends on dmfe_pkg and the assertion header.
`include "dhcp_message_field_extractor_top_assert.svh"

module dmfe_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  logic           accept,
  input  logic [7:0]     frame_byte,
  input  logic           frame_end,
  output dmfe_pkg::push_t push
);
  import dmfe_pkg::*;

  logic        request_mode;
  logic [9:0]  byte_offset, byte_offset_next;
  phase_t      walk_phase, walk_phase_next;
  logic [7:0]  option_code, option_code_next;
  logic [7:0]  option_remaining, option_remaining_next;
  logic [7:0]  data_position, data_position_next;
  logic [47:0] gather, gather_next;
  logic [1:0]  error_code, error_code_next;

  logic        have;
  logic [4:0]  kind;
  logic [47:0] value;
  logic [7:0]  index;
  logic [1:0]  status;

  always_comb begin
    logic [47:0] shifted;
    logic [7:0]  got;
    logic [4:0]  dkind;
    shifted = {gather[39:0], frame_byte};
    got = (data_position != 8'hFF) ? data_position + 8'd1 : 8'hFF;
    dkind = KIND_DONE;
    byte_offset_next = byte_offset;
    walk_phase_next = walk_phase;
    option_code_next = option_code;
    option_remaining_next = option_remaining;
    data_position_next = data_position;
    gather_next = gather;
    error_code_next = error_code;
    have = 1'b0;
    kind = KIND_DONE;
    value = '0;
    index = '0;

    unique case (walk_phase)
      PH_HEADER: begin
        gather_next = shifted;
        if (byte_offset == OFF_OP) begin
          have = 1'b1;
          kind = KIND_OP;
          value = {40'd0, frame_byte};
          if (request_mode && frame_byte != 8'd1) error_code_next = ST_WRONG_OP;
        end else if (byte_offset == OFF_XID_END) begin
          have = 1'b1;
          kind = KIND_XID;
          value = {16'd0, shifted[31:0]};
        end else if (byte_offset == OFF_YIADDR_END && !request_mode) begin
          have = 1'b1;
          kind = KIND_YIADDR;
          value = {16'd0, shifted[31:0]};
        end else if (byte_offset == OFF_SIADDR_END && !request_mode) begin
          have = 1'b1;
          kind = KIND_SIADDR;
          value = {16'd0, shifted[31:0]};
        end else if (byte_offset == OFF_GIADDR_END && !request_mode) begin
          have = 1'b1;
          kind = KIND_GIADDR;
          value = {16'd0, shifted[31:0]};
        end else if (byte_offset == OFF_MAC_END) begin
          have = 1'b1;
          kind = KIND_MAC;
          value = shifted;
        end else if (byte_offset == OFF_COOKIE_END) begin
          // an opcode error already found wins over the cookie check
          if (error_code != ST_OK) begin
            walk_phase_next = PH_SKIP;
          end else if (shifted[31:0] != COOKIE) begin
            error_code_next = ST_BAD_COOKIE;
            walk_phase_next = PH_SKIP;
          end else begin
            walk_phase_next = PH_CODE;
          end
        end
      end
      PH_CODE: begin
        if (byte_offset >= AREA_END || frame_byte == OPT_END) begin
          walk_phase_next = PH_STOP;
        end else if (frame_byte != OPT_PAD) begin
          option_code_next = frame_byte;
          walk_phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        option_remaining_next = frame_byte;
        data_position_next = '0;
        gather_next = '0;
        walk_phase_next = (frame_byte == 8'd0) ? PH_CODE : PH_DATA;
      end
      PH_DATA: begin
        gather_next = shifted;
        data_position_next = got;
        if (option_code == OPT_MSGTYPE) begin
          if (got == 8'd1) begin
            have = 1'b1;
            kind = KIND_MSGTYPE;
            value = {40'd0, frame_byte};
          end
        end else if (!request_mode) begin
          unique case (option_code)
            OPT_ROUTER: dkind = KIND_ROUTER;
            OPT_MASK:   dkind = KIND_MASK;
            OPT_SERVER: dkind = KIND_SERVER;
            OPT_RENEW:  dkind = KIND_RENEW;
            OPT_REBIND: dkind = KIND_REBIND;
            OPT_LEASE:  dkind = KIND_LEASE;
            OPT_DNS:    dkind = (got == 8'd8) ? KIND_DNS2 : KIND_DNS1;
            default:    dkind = KIND_DONE;
          endcase
          if (dkind != KIND_DONE && (got == 8'd4 || (dkind == KIND_DNS2 && got == 8'd8)))
          begin
            have = 1'b1;
            kind = dkind;
            value = {16'd0, shifted[31:0]};
          end else if (option_code == OPT_DOMAIN && {1'b0, data_position} < NAME_LIMIT) begin
            have = 1'b1;
            kind = KIND_NAME;
            value = {40'd0, frame_byte};
            index = data_position;
          end
        end
        option_remaining_next = option_remaining - 8'd1;
        if (option_remaining_next == 8'd0) walk_phase_next = PH_CODE;
      end
      default: begin
        // stopped or skipping: drop the byte
      end
    endcase

    if (byte_offset != OFFSET_MAX) byte_offset_next = byte_offset + 10'd1;

    if (error_code_next != ST_OK) begin
      status = error_code_next;
    end else if (walk_phase_next == PH_HEADER || walk_phase_next == PH_CODE ||
                 walk_phase_next == PH_LEN || walk_phase_next == PH_DATA) begin
      status = ST_EARLY_END;
    end else begin
      status = ST_OK;
    end

    // re-arm for the next frame after its last byte
    if (frame_end) begin
      byte_offset_next = '0;
      walk_phase_next = PH_HEADER;
      option_code_next = '0;
      option_remaining_next = '0;
      data_position_next = '0;
      gather_next = '0;
      error_code_next = ST_OK;
    end
  end

  always_comb begin
    result_t field_res;
    result_t done_res;
    field_res = '{kind: kind, value: value, index: index, status: ST_OK, last: !frame_end};
    done_res = '{kind: KIND_DONE, value: '0, index: '0, status: status, last: 1'b1};
    push.first_valid = accept && (have || frame_end);
    push.second_valid = accept && have && frame_end;
    push.first = have ? field_res : done_res;
    push.second = done_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_mode <= 1'b0;
      byte_offset <= '0;
      walk_phase <= PH_HEADER;
      option_code <= '0;
      option_remaining <= '0;
      data_position <= '0;
      gather <= '0;
      error_code <= ST_OK;
    end else begin
      if (cfg_we) request_mode <= cfg_wdata;
      if (accept) begin
        byte_offset <= byte_offset_next;
        walk_phase <= walk_phase_next;
        option_code <= option_code_next;
        option_remaining <= option_remaining_next;
        data_position <= data_position_next;
        gather <= gather_next;
        error_code <= error_code_next;
      end
    end
  end

  `DMFE_ASSERT_NEXT(a_rearm, accept && frame_end, byte_offset == 10'd0 && walk_phase == PH_HEADER, "parser did not re-arm after frame end")
  `DMFE_ASSERT_IMP(a_data_len, walk_phase == PH_DATA, option_remaining != 8'd0, "data phase with no bytes left")
  `DMFE_ASSERT_IMP(a_two_needs_end, push.second_valid, push.first_valid && frame_end, "second result without frame end")

endmodule

// ----- src/dmfe_out_fifo.sv -----
// Result queue: takes up to two results per cycle, hands out one per word.
// Depends on dmfe_pkg and the assertion header.
`include "dhcp_message_field_extractor_top_assert.svh"

module dmfe_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  dmfe_pkg::push_t   push,
  input  logic              pop_ready,
  output dmfe_pkg::result_t head,
  output logic              head_valid,
  output logic              space_ok
);
  import dmfe_pkg::*;

  result_t mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic [1:0] n_push;
  logic pop;

  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];
  assign pop = head_valid && pop_ready;
  // room for the two results a byte may bring
  assign space_ok = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign n_push = {1'b0, push.first_valid} + {1'b0, push.second_valid};
  assign count_next = count + CNT_W'(n_push) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.first_valid) mem[wr_ptr] <= push.first;
    if (push.second_valid) mem[wr_ptr + PTR_W'(1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count_next;
    end
  end

  `DMFE_ASSERT(a_no_overflow, count <= CNT_W'(FIFO_DEPTH), "result queue overflow")
  `DMFE_ASSERT_IMP(a_push_room, push.first_valid, space_ok, "push without room")
  `DMFE_ASSERT_NEXT(a_count_two, push.second_valid && !pop, count == $past(count) + CNT_W'(2), "double push miscounted")

endmodule

// ----- src/dhcp_message_field_extractor_top.sv -----
// Top level of the DHCP field extractor: parser plus result queue.
// Depends on dmfe_pkg, dmfe_parser, dmfe_out_fifo and the assertion header.
//
// Usage:
//   Message bytes enter on the frame channel (frame_valid/frame_ready, frame_byte,
//   frame_end marking the message's last byte). Results leave on the result
//   channel (result_valid/result_ready) as tagged words: field_kind, field_value,
//   name_index, parse_status, run_last. cfg_we/cfg_wdata write request_mode;
//   write it only between messages while no results are pending.
//   Each byte is parsed in the cycle it is accepted; its results sit in a
//   four-word queue and are offered from the next cycle on. One byte is taken
//   every cycle while frame_ready is high. A byte yields at most two words; the
//   last byte of a message adds the done word, absorbed by the queue. The queue
//   depth sets frame_ready: it drops while three or more words wait, so a
//   stalled receiver backs up the input after at most four words. Reset clears
//   the parse state, request_mode and the queue; no clearing pass follows.
`include "dhcp_message_field_extractor_top_assert.svh"

module dhcp_message_field_extractor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        frame_valid,
  output logic        frame_ready,
  input  logic [7:0]  frame_byte,
  input  logic        frame_end,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [4:0]  field_kind,
  output logic [47:0] field_value,
  output logic [7:0]  name_index,
  output logic [1:0]  parse_status,
  output logic        run_last
);
  import dmfe_pkg::*;

  push_t   push;
  result_t head;
  logic    space_ok;
  logic    accept;

  assign frame_ready = space_ok;
  assign accept = frame_valid && space_ok;

  dmfe_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .frame_byte (frame_byte),
    .frame_end  (frame_end),
    .push       (push)
  );

  dmfe_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop_ready  (result_ready),
    .head       (head),
    .head_valid (result_valid),
    .space_ok   (space_ok)
  );

  assign field_kind = head.kind;
  assign field_value = head.value;
  assign name_index = head.index;
  assign parse_status = head.status;
  assign run_last = head.last;

  `DMFE_ASSERT_IMP(a_done_last, result_valid && field_kind == KIND_DONE, run_last && field_value == 48'd0, "done word malformed")
  `DMFE_ASSERT_IMP(a_status_done, result_valid && parse_status != ST_OK, field_kind == KIND_DONE, "status on a field word")
  `DMFE_ASSERT_IMP(a_index_name, result_valid && name_index != 8'd0, field_kind == KIND_NAME, "index on a non-name word")

endmodule
